// File: hw/rtl/dees_pkg.sv
// ----------------------------------------------------------------------------
// dees_pkg
// Shared constants and types for the debounce edge event scanner.
// ----------------------------------------------------------------------------
package dees_pkg;

  // Number of pin channels, 1..32
  localparam int unsigned Channels = 6;
  // Change counter and threshold width
  localparam int unsigned CntW = 8;
  // Event code: 0 none, 1..Channels on, Channels+1..2*Channels off
  localparam int unsigned EvW = $clog2(2 * Channels + 1);
  // Threshold value after reset
  localparam logic [CntW-1:0] ThresholdReset = CntW'(10);
  // No event
  localparam logic [EvW-1:0] EvNone = '0;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [EvW-1:0]  ev_t;

  // Control shared by every cell of the row
  typedef struct packed {
    logic accept;
    cnt_t threshold;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/debounce_edge_event_scanner_unit.sv
// ----------------------------------------------------------------------------
// debounce_edge_event_scanner_unit
// Counter debouncer for active-low pins with on/off edge events.
// ----------------------------------------------------------------------------
// The result beat is registered and valid the cycle after the input beat is accepted.
// Throughput: one beat per cycle; the output register refills in the cycle it
//   is drained, so input ready is only low while a result is held back.
// Reset: asynchronous, active low; counters, levels and flags clear, the
//   threshold returns to 10 and no result is pending.
// ----------------------------------------------------------------------------
module debounce_edge_event_scanner_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  dees_pkg::cnt_t                    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dees_pkg::Channels-1:0]     pin_levels_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dees_pkg::ev_t                     event_code_o,
  output logic [dees_pkg::Channels-1:0]     debounced_levels_o
);
  import dees_pkg::*;

  // Sample threshold register; the user must write it only while idle, the block does not enforce this
  cnt_t threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  // Handshake: a new beat may enter when the output register is empty or is
  // being drained in this very cycle.
  logic out_valid_q;
  logic in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  cell_ctrl_t ctrl;
  assign ctrl.accept    = in_accept;
  assign ctrl.threshold = threshold_q;

  // Row of cells. The event code ripples from channel 0 upward; each cell
  // with its own edge overrides it, so the highest channel wins.
  ev_t                 ev_chain [Channels+1];
  logic [Channels-1:0] levels_next;

  assign ev_chain[0] = EvNone;

  for (genvar k = 0; k < Channels; k++) begin : g_cell
    dees_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .raw_active_i (!pin_levels_i[k]),     // pins are active low
      .on_code_i    (EvW'(k + 1)),
      .off_code_i   (EvW'(Channels + k + 1)),
      .event_i      (ev_chain[k]),
      .event_o      (ev_chain[k+1]),
      .level_next_o (levels_next[k])
    );
  end

  // Output register
  ev_t                 event_q;
  logic [Channels-1:0] levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      event_q  <= ev_chain[Channels];
      levels_q <= levels_next;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_code_o       = event_q;
  assign debounced_levels_o = levels_q;

  // Assertions
  a_accept_gives_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted beat gave no result");

  a_event_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o <= EvW'(2 * Channels)))
    else $error("event code out of range");

  a_levels_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(debounced_levels_o) && $stable(event_code_o))
    else $error("held result changed");

  a_threshold_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(threshold_q))
    else $error("threshold changed without a write");

endmodule

// File: hw/rtl/dees_cell.sv
// ----------------------------------------------------------------------------
// dees_cell
// One debounce channel: change counter, debounced level and release-wait
// flag. Passes the event code along the row, overriding it on its own edge.
// ----------------------------------------------------------------------------
module dees_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dees_pkg::cell_ctrl_t ctrl_i,
  input  logic                raw_active_i,
  input  dees_pkg::ev_t       on_code_i,
  input  dees_pkg::ev_t       off_code_i,
  input  dees_pkg::ev_t       event_i,
  output dees_pkg::ev_t       event_o,
  output logic                level_next_o
);
  import dees_pkg::*;

  cnt_t cnt_q, cnt_d, cnt_inc;
  logic stable_q, stable_d;
  logic wait_q, wait_d;

  always_comb begin
    cnt_inc  = cnt_q + CntW'(1);
    stable_d = stable_q;
    cnt_d    = '0;
    if (raw_active_i != stable_q) begin
      if (cnt_inc == ctrl_i.threshold) begin
        stable_d = raw_active_i;
      end else begin
        cnt_d = cnt_inc;
      end
    end
    wait_d = stable_d;

    event_o = event_i;
    if (stable_d && !wait_q) begin
      event_o = on_code_i;
    end else if (!stable_d && wait_q) begin
      event_o = off_code_i;
    end
  end

  assign level_next_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      stable_q <= 1'b0;
      wait_q   <= 1'b0;
    end else if (ctrl_i.accept) begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
      wait_q   <= wait_d;
    end
  end

endmodule

// File: tb/dees_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// dees_scoreboard_pkg
// Scoreboard for the debounce edge event scanner. It keeps its own copy of
// the per-channel counters, settled levels and armed flags, predicts the
// report of every accepted sample beat and checks the result beats in order.
// ----------------------------------------------------------------------------
package dees_scoreboard_pkg;

  import dees_pkg::*;

  typedef struct packed {
    ev_t                 code;
    logic [Channels-1:0] levels;
  } tick_report_t;

  class debounce_scoreboard;

    cnt_t         threshold;
    cnt_t         bounce_cnt [Channels];
    bit           settled    [Channels];
    bit           armed      [Channels];
    tick_report_t expected_reports [$];
    int unsigned  errors;
    int unsigned  results_seen;

    function new();
      threshold = ThresholdReset;
      foreach (bounce_cnt[k]) begin
        bounce_cnt[k] = '0;
        settled[k]    = 1'b0;
        armed[k]      = 1'b0;
      end
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_threshold(cnt_t value);
      threshold = value;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // One sample tick: update every channel, later channels override the code.
    function void note_sample(logic [Channels-1:0] pins);
      tick_report_t report;
      logic         active;
      report.code   = EvNone;
      report.levels = '0;
      for (int k = 0; k < Channels; k++) begin
        active = ~pins[k];
        if (active != settled[k]) begin
          bounce_cnt[k] = bounce_cnt[k] + 1'b1;  // 8-bit wrap, zero means 256
          if (bounce_cnt[k] == threshold) begin
            settled[k]    = active;
            bounce_cnt[k] = '0;
          end
        end else begin
          bounce_cnt[k] = '0;
        end
        if (settled[k]) begin
          if (!armed[k]) report.code = ev_t'(k + 1);
          armed[k]         = 1'b1;
          report.levels[k] = 1'b1;
        end else begin
          if (armed[k]) report.code = ev_t'(Channels + k + 1);
          armed[k] = 1'b0;
        end
      end
      expected_reports.push_back(report);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(ev_t code, logic [Channels-1:0] levels);
      tick_report_t want;
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected: event %0d levels %02h",
                                  results_seen, code, levels));
        return;
      end
      want = expected_reports.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("result beat %0d event_code %0d, expected %0d",
                                  results_seen, code, want.code));
      if (levels !== want.levels)
        report_mismatch($sformatf("result beat %0d debounced_levels %02h, expected %02h",
                                  results_seen, levels, want.levels));
    endtask

  endclass

endpackage

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for debounce_edge_event_scanner_unit. Directed sample beats hit
// all-channel edges and every on and off code, then bouncing pin patterns
// held for about the threshold run under several thresholds, including 1,
// 255 and 0 (256 samples). Both channels idle at random; the receiver also
// holds off for a long stretch and the sender pauses until drained.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import dees_pkg::*;
  import dees_scoreboard_pkg::*;

  localparam int unsigned HoldCycles = 60;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  cnt_t                cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [Channels-1:0] pin_levels_i = '1;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  ev_t                 event_code_o;
  logic [Channels-1:0] debounced_levels_o;

  debounce_scoreboard sb = new();

  // Random idling on both sides while set
  bit          idle_en       = 1'b1;
  // Long receiver hold-offs: requested by the stimulus, served by the sink
  int unsigned hold_requests = 0;

  // Pattern generator state
  cnt_t                thr_now   = ThresholdReset;
  logic [Channels-1:0] held_pins = '1;
  logic [Channels-1:0] prev_pins = '1;
  int unsigned         run_left  = 0;
  int unsigned         run_pos   = 0;
  int unsigned         bounce_len = 0;

  debounce_edge_event_scanner_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pin_levels_i      (pin_levels_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_code_o      (event_code_o),
    .debounced_levels_o(debounced_levels_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(pin_levels_i);
      if (out_valid_o && out_ready_i) sb.check_result(event_code_o, debounced_levels_o);
    end
  end

  // Result sink: random back-pressure, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99, 0) < 24);
      end
    end
  end

  // One sample beat. Valid stays high from the previous beat unless an idle
  // cycle is drawn, so it is never dropped and raised in the same step.
  task automatic send_sample(input logic [Channels-1:0] pins);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99, 0) < 24) begin
      in_valid_i   <= 1'b0;
      pin_levels_i <= Channels'($urandom);  // junk while idle, must be ignored
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= pins;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Threshold writes only with nothing in flight; every beat gives a result,
  // so an empty expectation queue means the block is idle.
  task automatic write_threshold(input cnt_t value);
    stop_sending();
    wait_for_results();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    sb.set_threshold(value);
    thr_now = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Bouncing patterns: each run starts with a few beats flickering between
  // the old and new pattern, then holds the new one for about the threshold.
  // Some runs are cut short so that the counters clear before the change.
  task automatic run_samples(input int unsigned count);
    int unsigned         span;
    logic [Channels-1:0] pins;
    span = (thr_now == '0) ? 256 : int'(thr_now);
    repeat (count) begin
      if (run_left == 0) begin
        prev_pins = held_pins;
        if ($urandom_range(3, 0) == 0)
          held_pins = held_pins ^ (Channels'(1) << $urandom_range(Channels - 1, 0));
        else
          held_pins = Channels'($urandom);
        bounce_len = $urandom_range(4, 0);
        if ($urandom_range(5, 0) == 0) run_left = $urandom_range(span, 1);
        else run_left = span + bounce_len + $urandom_range(4, 0);
        run_pos = 0;
      end
      if (run_pos < bounce_len)
        pins = $urandom_range(1, 0) ? held_pins : prev_pins;
      else if (span <= 10 && $urandom_range(19, 0) == 0)
        pins = Channels'($urandom);  // stray glitch
      else
        pins = held_pins;
      run_pos++;
      run_left--;
      send_sample(pins);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset threshold of 10: every channel goes active together, so the
    // sixth channel's on code must win; a short glitch back clears the
    // counters; then every channel releases together.
    repeat (2) send_sample('1);
    repeat (10) send_sample('0);
    repeat (2) send_sample('1);
    send_sample('0);
    repeat (10) send_sample('1);

    // Threshold 1: walk one active channel at a time for every on and off code.
    write_threshold(cnt_t'(1));
    for (int k = 0; k < Channels; k++) begin
      send_sample(~(Channels'(1) << k));
      send_sample('1);
    end
    run_samples(90);
    hold_requests++;
    run_samples(90);

    // Largest threshold
    write_threshold(cnt_t'(255));
    run_left = 0;
    run_samples(300);

    // No random idling on either side here, with one long hold-off
    write_threshold(cnt_t'(3));
    run_left = 0;
    idle_en  = 1'b0;
    run_samples(60);
    hold_requests++;
    run_samples(120);
    stop_sending();
    idle_en  = 1'b1;

    // Zero threshold wraps the 8-bit counter: 256 differing samples
    write_threshold(cnt_t'(0));
    run_left = 0;
    run_samples(300);

    // Sender pauses mid-phase until every result is back
    write_threshold(cnt_t'(2));
    run_left = 0;
    run_samples(70);
    stop_sending();
    wait_for_results();
    run_samples(80);

    write_threshold(cnt_t'($urandom_range(20, 4)));
    run_left = 0;
    run_samples(150);

    stop_sending();
    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under 20 us.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: debounce_edge_event_scanner_unit.f
hw/rtl/dees_pkg.sv
hw/rtl/dees_cell.sv
hw/rtl/debounce_edge_event_scanner_unit.sv
tb/dees_scoreboard_pkg.sv
tb/tb_top.sv
